// File: design/atsp_pkg.sv
// shared types and constants for the modem status parser
package atsp_pkg;

    localparam int unsigned LINE_CAP = 159;
    localparam int unsigned LEN_W = 8;
    localparam int unsigned NPAT = 4;
    localparam int unsigned PROG_W = 3;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned OUT_DEPTH = 2;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_POLL = 2'd2;

    localparam logic [31:0] RST_ENABLE = 32'd1;
    localparam logic [31:0] RST_TIMEOUT = 32'd30000;
    localparam logic [31:0] RST_POLL = 32'd5000;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [5:0] CSQ_UNKNOWN = 6'h3F;
    localparam logic [7:0] CSQ_MAX = 8'd31;
    localparam logic [7:0] RSSI_BASE = 8'h8F;     // -113
    localparam logic [7:0] RSSI_UNKNOWN = 8'h81;  // -127

    // pattern 0 "+CPIN:", 1 "READY", 2 "+CGATT:", 3 "+CSQ:"
    localparam logic [0:NPAT-1][0:7][7:0] PAT_TEXT = {
        {"+CPIN:", 16'h0000},
        {"READY", 24'h000000},
        {"+CGATT:", 8'h00},
        {"+CSQ:", 24'h000000}
    };
    localparam logic [0:NPAT-1][PROG_W-1:0] PAT_LEN = {3'd6, 3'd5, 3'd7, 3'd5};

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_CR,
        KIND_LF,
        KIND_ZERO,
        KIND_CHAR
    } t_kind;

    typedef enum logic [1:0] {
        NUM_WAIT_COLON,
        NUM_WAIT_START,
        NUM_DIGITS,
        NUM_DONE
    } t_num_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       blank;
        logic       colon;
        logic       num_space;
        logic       sign;
        logic       minus;
        logic       digit;
        logic [3:0] digit_val;
    } t_item;

    typedef struct packed {
        logic        enable;
        logic [31:0] online_timeout_ms;
        logic [31:0] poll_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic              online;
        logic              sim_ready;
        logic              attached;
        logic signed [5:0] signal_quality;
        logic signed [7:0] rssi_dbm;
        logic              line_accepted;
        logic              probe_issue;
        logic [1:0]        probe_command;
    } t_result;

endpackage

// File: design/at_response_status_parser_unit.sv
// modem AT response status parser: top level with configuration registers
//
// Input queue side: present i_op (0 byte, 1 millisecond tick) and i_rx_byte
// with push; a word is taken at each clock edge where push is high and full
// is low. Result side: while empty is low the oldest result word sits on the
// o_* ports and leaves at an edge where pop is high. Every input word yields
// exactly one result word with the status flags after that word.
// A word passes the input queue and then the result queue before empty
// goes low; one word per cycle is sustained as long as pop keeps up. A
// four-word queue behind the classifier and a two-word result queue let
// either side stall on its own: when pop stays low the result queue fills,
// then the input queue, and full rises after six waiting words.
// APB registers (4-byte spacing): 0 enable, 1 online_timeout_ms,
// 2 poll_interval_ms; write them only while no word is in flight.
// Synchronous active-low reset empties both queues, clears all status, sets
// signal quality unknown, and arms the probe timer so the first tick probes.
module at_response_status_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              push,
    output logic              full,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    // result channel
    output logic              empty,
    input  logic              pop,
    output logic              o_online,
    output logic              o_sim_ready,
    output logic              o_attached,
    output logic signed [5:0] o_signal_quality,
    output logic signed [7:0] o_rssi_dbm,
    output logic              o_line_accepted,
    output logic              o_probe_issue,
    output logic [1:0]        o_probe_command,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    atsp_pkg::t_cfg    r_cfg;
    atsp_pkg::t_item   w_item;
    atsp_pkg::t_result w_result;
    logic              w_valid;
    logic              w_take;
    logic              w_cfg_wr;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= atsp_pkg::RST_ENABLE[0];
            r_cfg.online_timeout_ms <= atsp_pkg::RST_TIMEOUT;
            r_cfg.poll_interval_ms <= atsp_pkg::RST_POLL;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                atsp_pkg::REG_ENABLE:  r_cfg.enable <= pwdata[0];
                atsp_pkg::REG_TIMEOUT: r_cfg.online_timeout_ms <= pwdata;
                atsp_pkg::REG_POLL:    r_cfg.poll_interval_ms <= pwdata;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            atsp_pkg::REG_ENABLE:  prdata = {31'h0, r_cfg.enable};
            atsp_pkg::REG_TIMEOUT: prdata = r_cfg.online_timeout_ms;
            atsp_pkg::REG_POLL:    prdata = r_cfg.poll_interval_ms;
            default:               prdata = '0;
        endcase
    end

    atsp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_op      (i_op),
        .i_rx_byte (i_rx_byte),
        .o_full    (full),
        .i_take    (w_take),
        .o_valid   (w_valid),
        .o_item    (w_item)
    );

    atsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (w_result)
    );

    assign o_online = w_result.online;
    assign o_sim_ready = w_result.sim_ready;
    assign o_attached = w_result.attached;
    assign o_signal_quality = w_result.signal_quality;
    assign o_rssi_dbm = w_result.rssi_dbm;
    assign o_line_accepted = w_result.line_accepted;
    assign o_probe_issue = w_result.probe_issue;
    assign o_probe_command = w_result.probe_command;

endmodule

// File: design/atsp_front.sv
// front end: classifies each byte or tick and queues it for the back end
module atsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_op,
    input  logic [7:0]        i_rx_byte,
    output logic              o_full,
    input  logic              i_take,
    output logic              o_valid,
    output atsp_pkg::t_item   o_item
);

    atsp_pkg::t_item                 w_item;
    atsp_pkg::t_item                 r_q [atsp_pkg::Q_DEPTH];
    logic [atsp_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [atsp_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [atsp_pkg::Q_PTR_W:0]      r_count;
    logic [atsp_pkg::Q_PTR_W:0]      n_count;
    logic                            w_wr;
    logic                            w_rd;

    always_comb begin
        w_item.ch = i_rx_byte;
        w_item.blank = (i_rx_byte == atsp_pkg::CH_SPACE) || (i_rx_byte == atsp_pkg::CH_TAB);
        w_item.colon = (i_rx_byte == atsp_pkg::CH_COLON);
        w_item.num_space = w_item.blank || (i_rx_byte == atsp_pkg::CH_VT)
                           || (i_rx_byte == atsp_pkg::CH_FF);
        w_item.sign = (i_rx_byte == atsp_pkg::CH_PLUS) || (i_rx_byte == atsp_pkg::CH_MINUS);
        w_item.minus = (i_rx_byte == atsp_pkg::CH_MINUS);
        w_item.digit = (i_rx_byte >= atsp_pkg::CH_ZERO) && (i_rx_byte <= atsp_pkg::CH_NINE);
        w_item.digit_val = i_rx_byte[3:0];
        if (i_op) begin
            w_item.kind = atsp_pkg::KIND_TICK;
        end else if (i_rx_byte == atsp_pkg::CH_CR) begin
            w_item.kind = atsp_pkg::KIND_CR;
        end else if (i_rx_byte == atsp_pkg::CH_LF) begin
            w_item.kind = atsp_pkg::KIND_LF;
        end else if (i_rx_byte == atsp_pkg::CH_NUL) begin
            w_item.kind = atsp_pkg::KIND_ZERO;
        end else begin
            w_item.kind = atsp_pkg::KIND_CHAR;
        end
    end

    assign o_full = (r_count == (atsp_pkg::Q_PTR_W + 1)'(atsp_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item = r_q[r_rd_ptr];
    assign w_wr = i_push && !o_full;
    assign w_rd = i_take && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

// File: design/atsp_back.sv
// back end: line assembly, pattern and number matching, timers, result queue
module atsp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atsp_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  atsp_pkg::t_item    i_item,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output atsp_pkg::t_result  o_result
);

    // line state
    logic [atsp_pkg::LEN_W-1:0]  r_line_len, n_line_len;
    logic                        r_content_ended, n_content_ended;
    logic                        r_nonblank, n_nonblank;
    logic [atsp_pkg::PROG_W-1:0] r_prog [atsp_pkg::NPAT];
    logic [atsp_pkg::PROG_W-1:0] n_prog [atsp_pkg::NPAT];
    logic [atsp_pkg::NPAT-1:0]   r_found, n_found;
    atsp_pkg::t_num_phase        r_phase, n_phase;
    logic                        r_neg, n_neg;
    logic [7:0]                  r_mag, n_mag;
    // link status
    logic                        r_online, n_online;
    logic                        r_sim_ready, n_sim_ready;
    logic                        r_attached, n_attached;
    logic [5:0]                  r_csq, n_csq;
    logic                        r_ever, n_ever;
    logic [31:0]                 r_rx_age, n_rx_age;
    logic [31:0]                 r_probe_age, n_probe_age;
    logic [1:0]                  r_probe_step, n_probe_step;

    // per-character updates
    logic [atsp_pkg::PROG_W-1:0] f_prog [atsp_pkg::NPAT];
    logic [atsp_pkg::NPAT-1:0]   f_found;
    atsp_pkg::t_num_phase        f_phase;
    logic                        f_neg;
    logic [7:0]                  f_mag;
    logic [11:0]                 w_mag_x10;

    logic                        w_feed;
    logic                        w_clear;
    logic                        w_accept;
    logic                        w_issue;
    logic [1:0]                  w_cmd;
    logic                        w_csq_ok;
    atsp_pkg::t_result           w_res;

    // result queue
    atsp_pkg::t_result           r_out [atsp_pkg::OUT_DEPTH];
    logic [atsp_pkg::OUT_PTR_W-1:0] r_out_wr;
    logic [atsp_pkg::OUT_PTR_W-1:0] r_out_rd;
    logic [atsp_pkg::OUT_PTR_W:0]   r_out_cnt;
    logic                        w_out_rd;

    assign o_take = i_valid
                    && (r_out_cnt != (atsp_pkg::OUT_PTR_W + 1)'(atsp_pkg::OUT_DEPTH));
    assign o_empty = (r_out_cnt == '0);
    assign o_result = r_out[r_out_rd];
    assign w_out_rd = i_pop && !o_empty;

    // substring matchers, none of the patterns has a border
    always_comb begin
        for (int i = 0; i < atsp_pkg::NPAT; i++) begin
            f_prog[i] = r_prog[i];
            f_found[i] = r_found[i];
            if (!r_found[i]) begin
                if ((r_prog[i] < atsp_pkg::PAT_LEN[i])
                        && (i_item.ch == atsp_pkg::PAT_TEXT[i][r_prog[i]])) begin
                    f_prog[i] = r_prog[i] + 1'b1;
                end else if (i_item.ch == atsp_pkg::PAT_TEXT[i][0]) begin
                    f_prog[i] = atsp_pkg::PROG_W'(1);
                end else begin
                    f_prog[i] = '0;
                end
                if (f_prog[i] >= atsp_pkg::PAT_LEN[i]) begin
                    f_found[i] = 1'b1;
                    f_prog[i] = '0;
                end
            end
        end
    end

    // value after the first colon, atoi style
    assign w_mag_x10 = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                       + {8'h00, i_item.digit_val};

    always_comb begin
        f_phase = r_phase;
        f_neg = r_neg;
        f_mag = r_mag;
        unique case (r_phase)
            atsp_pkg::NUM_WAIT_COLON: begin
                if (i_item.colon) begin
                    f_phase = atsp_pkg::NUM_WAIT_START;
                end
            end
            atsp_pkg::NUM_WAIT_START: begin
                priority if (i_item.num_space) begin
                    f_phase = r_phase;
                end else if (i_item.sign) begin
                    f_neg = i_item.minus;
                    f_phase = atsp_pkg::NUM_DIGITS;
                end else if (i_item.digit) begin
                    f_mag = {4'h0, i_item.digit_val};
                    f_phase = atsp_pkg::NUM_DIGITS;
                end else begin
                    f_phase = atsp_pkg::NUM_DONE;
                end
            end
            atsp_pkg::NUM_DIGITS: begin
                if (i_item.digit) begin
                    f_mag = (w_mag_x10 > 12'd255) ? 8'hFF : w_mag_x10[7:0];
                end else begin
                    f_phase = atsp_pkg::NUM_DONE;
                end
            end
            atsp_pkg::NUM_DONE: begin
                f_phase = r_phase;
            end
        endcase
    end

    assign w_csq_ok = (r_mag <= atsp_pkg::CSQ_MAX) && (!r_neg || (r_mag == 8'h00));

    always_comb begin
        n_line_len = r_line_len;
        n_content_ended = r_content_ended;
        n_nonblank = r_nonblank;
        n_prog = r_prog;
        n_found = r_found;
        n_phase = r_phase;
        n_neg = r_neg;
        n_mag = r_mag;
        n_online = r_online;
        n_sim_ready = r_sim_ready;
        n_attached = r_attached;
        n_csq = r_csq;
        n_ever = r_ever;
        n_rx_age = r_rx_age;
        n_probe_age = r_probe_age;
        n_probe_step = r_probe_step;
        w_feed = 1'b0;
        w_clear = 1'b0;
        w_accept = 1'b0;
        w_issue = 1'b0;
        w_cmd = 2'd0;
        if (o_take && i_cfg.enable) begin
            unique case (i_item.kind)
                atsp_pkg::KIND_TICK: begin
                    if (r_rx_age != '1) begin
                        n_rx_age = r_rx_age + 32'd1;
                    end
                    if (r_ever && (n_rx_age > i_cfg.online_timeout_ms)) begin
                        n_online = 1'b0;
                        n_attached = 1'b0;
                        n_csq = atsp_pkg::CSQ_UNKNOWN;
                    end
                    if (r_probe_age != '1) begin
                        n_probe_age = r_probe_age + 32'd1;
                    end
                    if (n_probe_age >= i_cfg.poll_interval_ms) begin
                        n_probe_age = '0;
                        w_issue = 1'b1;
                        w_cmd = r_probe_step;
                        n_probe_step = r_probe_step + 2'd1;
                    end
                end
                atsp_pkg::KIND_CR: begin
                    w_feed = 1'b0;
                end
                atsp_pkg::KIND_LF: begin
                    if (r_line_len != '0) begin
                        w_clear = 1'b1;
                        w_accept = r_nonblank;
                    end
                end
                atsp_pkg::KIND_ZERO, atsp_pkg::KIND_CHAR: begin
                    if (r_line_len < atsp_pkg::LEN_W'(atsp_pkg::LINE_CAP)) begin
                        n_line_len = r_line_len + 1'b1;
                        if (!r_content_ended) begin
                            if (i_item.kind == atsp_pkg::KIND_ZERO) begin
                                n_content_ended = 1'b1;
                            end else begin
                                w_feed = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    w_feed = 1'b0;
                end
            endcase
        end

        if (w_accept) begin
            n_rx_age = '0;
            n_ever = 1'b1;
            n_online = 1'b1;
            priority if (r_found[0]) begin
                n_sim_ready = r_found[1];
            end else if (r_found[2]) begin
                n_attached = !r_neg && (r_mag == 8'd1);
            end else if (r_found[3]) begin
                n_csq = w_csq_ok ? r_mag[5:0] : atsp_pkg::CSQ_UNKNOWN;
            end
        end

        if (w_clear) begin
            n_line_len = '0;
            n_content_ended = 1'b0;
            n_nonblank = 1'b0;
            for (int i = 0; i < atsp_pkg::NPAT; i++) begin
                n_prog[i] = '0;
            end
            n_found = '0;
            n_phase = atsp_pkg::NUM_WAIT_COLON;
            n_neg = 1'b0;
            n_mag = '0;
        end else if (w_feed) begin
            if (!i_item.blank) begin
                n_nonblank = 1'b1;
            end
            n_prog = f_prog;
            n_found = f_found;
            n_phase = f_phase;
            n_neg = f_neg;
            n_mag = f_mag;
        end
    end

    always_comb begin
        w_res.online = n_online;
        w_res.sim_ready = n_sim_ready;
        w_res.attached = n_attached;
        w_res.signal_quality = n_csq;
        w_res.rssi_dbm = n_csq[5] ? atsp_pkg::RSSI_UNKNOWN
                                  : atsp_pkg::RSSI_BASE + {1'b0, n_csq, 1'b0};
        w_res.line_accepted = w_accept;
        w_res.probe_issue = w_issue;
        w_res.probe_command = w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_content_ended <= 1'b0;
            r_nonblank <= 1'b0;
            for (int i = 0; i < atsp_pkg::NPAT; i++) begin
                r_prog[i] <= '0;
            end
            r_found <= '0;
            r_phase <= atsp_pkg::NUM_WAIT_COLON;
            r_neg <= 1'b0;
            r_mag <= '0;
            r_online <= 1'b0;
            r_sim_ready <= 1'b0;
            r_attached <= 1'b0;
            r_csq <= atsp_pkg::CSQ_UNKNOWN;
            r_ever <= 1'b0;
            r_rx_age <= '0;
            r_probe_age <= '1;
            r_probe_step <= '0;
            r_out_wr <= '0;
            r_out_rd <= '0;
            r_out_cnt <= '0;
        end else begin
            r_line_len <= n_line_len;
            r_content_ended <= n_content_ended;
            r_nonblank <= n_nonblank;
            r_prog <= n_prog;
            r_found <= n_found;
            r_phase <= n_phase;
            r_neg <= n_neg;
            r_mag <= n_mag;
            r_online <= n_online;
            r_sim_ready <= n_sim_ready;
            r_attached <= n_attached;
            r_csq <= n_csq;
            r_ever <= n_ever;
            r_rx_age <= n_rx_age;
            r_probe_age <= n_probe_age;
            r_probe_step <= n_probe_step;
            if (o_take) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (w_out_rd) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
            if (o_take && !w_out_rd) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end else if (w_out_rd && !o_take) begin
                r_out_cnt <= r_out_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out[r_out_wr] <= w_res;
        end
    end

`ifndef SYNTHESIS
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt <= (atsp_pkg::OUT_PTR_W + 1)'(atsp_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_line_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= atsp_pkg::LEN_W'(atsp_pkg::LINE_CAP))
        else $error("line length past cap");

    a_probe_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> (r_probe_age == '0))
        else $error("probe age not restarted after probe");

    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_cfg.enable && (i_item.kind == atsp_pkg::KIND_LF)
            && (r_line_len != '0)) |=> (r_line_len == '0) && (r_found == '0))
        else $error("line not cleared at end of line");

    a_rssi_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_result.signal_quality == atsp_pkg::CSQ_UNKNOWN))
            |-> (o_result.rssi_dbm == atsp_pkg::RSSI_UNKNOWN))
        else $error("rssi inconsistent with unknown csq");
`endif

endmodule

// File: verif/at_response_status_parser_unit_tb.sv
// self-checking testbench for the modem AT response status parser
`timescale 1ns / 1ps

module at_response_status_parser_unit_tb;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int PAT_CPIN = 0;
    localparam int PAT_READY = 1;
    localparam int PAT_CGATT = 2;
    localparam int PAT_CSQ = 3;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_op;
    logic [7:0]        i_rx_byte;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_online;
    logic              o_sim_ready;
    logic              o_attached;
    logic signed [5:0] o_signal_quality;
    logic signed [7:0] o_rssi_dbm;
    logic              o_line_accepted;
    logic              o_probe_issue;
    logic [1:0]        o_probe_command;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // model of the parser
    logic        cfg_enable;
    logic [31:0] cfg_timeout;
    logic [31:0] cfg_poll;
    int          line_len;
    logic        content_done;
    logic        saw_nonblank;
    int          match_pos [atsp_pkg::NPAT];
    logic        match_hit [atsp_pkg::NPAT];
    atsp_pkg::t_num_phase num_state;
    logic        num_minus;
    int          num_value;
    logic        online_q;
    logic        sim_ready_q;
    logic        attached_q;
    int          csq_q;
    logic        heard_modem;
    logic [31:0] silence_ms;
    logic [31:0] since_probe_ms;
    logic [1:0]  next_probe;
    string       pat_text [atsp_pkg::NPAT] = '{"+CPIN:", "READY", "+CGATT:", "+CSQ:"};

    atsp_pkg::t_result expected_status [$];
    logic [7:0]  line_bytes [$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          tick_pct = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    at_response_status_parser_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_online         (o_online),
        .o_sim_ready      (o_sim_ready),
        .o_attached       (o_attached),
        .o_signal_quality (o_signal_quality),
        .o_rssi_dbm       (o_rssi_dbm),
        .o_line_accepted  (o_line_accepted),
        .o_probe_issue    (o_probe_issue),
        .o_probe_command  (o_probe_command),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_line();
        int i;
        line_len = 0;
        content_done = 1'b0;
        saw_nonblank = 1'b0;
        for (i = 0; i < atsp_pkg::NPAT; i++) begin
            match_pos[i] = 0;
            match_hit[i] = 1'b0;
        end
        num_state = atsp_pkg::NUM_WAIT_COLON;
        num_minus = 1'b0;
        num_value = 0;
    endfunction

    function automatic atsp_pkg::t_result predict_status(input logic op,
                                                         input logic [7:0] ch);
        atsp_pkg::t_result r;
        int      i;
        int      p;
        int      rssi;
        logic    accepted;
        logic    issue;
        logic [1:0] cmd;
        accepted = 1'b0;
        issue = 1'b0;
        cmd = 2'd0;
        if (cfg_enable) begin
            if (op == OP_BYTE) begin
                if (ch == atsp_pkg::CH_CR) begin
                    // carriage return never counts
                end else if (ch == atsp_pkg::CH_LF) begin
                    if (line_len > 0) begin
                        if (saw_nonblank) begin
                            silence_ms = '0;
                            heard_modem = 1'b1;
                            online_q = 1'b1;
                            if (match_hit[PAT_CPIN]) begin
                                sim_ready_q = match_hit[PAT_READY];
                            end else if (match_hit[PAT_CGATT]) begin
                                attached_q = !num_minus && num_value == 1;
                            end else if (match_hit[PAT_CSQ]) begin
                                csq_q = (num_value <= int'(atsp_pkg::CSQ_MAX) &&
                                         (!num_minus || num_value == 0)) ? num_value : -1;
                            end
                            accepted = 1'b1;
                        end
                        clear_line();
                    end
                end else if (line_len < atsp_pkg::LINE_CAP) begin
                    line_len++;
                    if (!content_done) begin
                        if (ch == atsp_pkg::CH_NUL) begin
                            content_done = 1'b1;
                        end else begin
                            if (ch != atsp_pkg::CH_SPACE && ch != atsp_pkg::CH_TAB)
                                saw_nonblank = 1'b1;
                            // substring search, a miss restarts at the first char
                            for (i = 0; i < atsp_pkg::NPAT; i++) begin
                                if (!match_hit[i]) begin
                                    p = match_pos[i];
                                    if (p < pat_text[i].len() && ch == pat_text[i][p]) p++;
                                    else p = (ch == pat_text[i][0]) ? 1 : 0;
                                    if (p >= pat_text[i].len()) begin
                                        match_hit[i] = 1'b1;
                                        p = 0;
                                    end
                                    match_pos[i] = p;
                                end
                            end
                            case (num_state)
                                atsp_pkg::NUM_WAIT_COLON: begin
                                    if (ch == atsp_pkg::CH_COLON)
                                        num_state = atsp_pkg::NUM_WAIT_START;
                                end
                                atsp_pkg::NUM_WAIT_START: begin
                                    if (ch == atsp_pkg::CH_SPACE || ch == atsp_pkg::CH_TAB ||
                                        ch == atsp_pkg::CH_VT || ch == atsp_pkg::CH_FF) begin
                                        // leading white space is skipped
                                    end else if (ch == atsp_pkg::CH_PLUS ||
                                                 ch == atsp_pkg::CH_MINUS) begin
                                        num_minus = (ch == atsp_pkg::CH_MINUS);
                                        num_state = atsp_pkg::NUM_DIGITS;
                                    end else if (ch >= atsp_pkg::CH_ZERO &&
                                                 ch <= atsp_pkg::CH_NINE) begin
                                        num_value = ch - atsp_pkg::CH_ZERO;
                                        num_state = atsp_pkg::NUM_DIGITS;
                                    end else begin
                                        num_state = atsp_pkg::NUM_DONE;
                                    end
                                end
                                atsp_pkg::NUM_DIGITS: begin
                                    if (ch >= atsp_pkg::CH_ZERO && ch <= atsp_pkg::CH_NINE) begin
                                        num_value = num_value * 10 + (ch - atsp_pkg::CH_ZERO);
                                        if (num_value > 255) num_value = 255;
                                    end else begin
                                        num_state = atsp_pkg::NUM_DONE;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end else begin
                if (silence_ms != '1) silence_ms++;
                if (heard_modem && silence_ms > cfg_timeout) begin
                    online_q = 1'b0;
                    attached_q = 1'b0;
                    csq_q = -1;
                end
                if (since_probe_ms != '1) since_probe_ms++;
                if (since_probe_ms >= cfg_poll) begin
                    since_probe_ms = '0;
                    issue = 1'b1;
                    cmd = next_probe;
                    next_probe++;
                end
            end
        end
        rssi = (csq_q >= 0 && csq_q <= int'(atsp_pkg::CSQ_MAX)) ? -113 + 2 * csq_q : -127;
        r.online = online_q;
        r.sim_ready = sim_ready_q;
        r.attached = attached_q;
        r.signal_quality = csq_q[5:0];
        r.rssi_dbm = rssi[7:0];
        r.line_accepted = accepted;
        r.probe_issue = issue;
        r.probe_command = cmd;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_status_word();
        atsp_pkg::t_result want;
        if (expected_status.size() == 0) begin
            report_mismatch("result word with no prediction waiting");
        end else begin
            want = expected_status.pop_front();
            compare_field("online", o_online, want.online);
            compare_field("sim_ready", o_sim_ready, want.sim_ready);
            compare_field("attached", o_attached, want.attached);
            compare_field("signal_quality", o_signal_quality, want.signal_quality);
            compare_field("rssi_dbm", o_rssi_dbm, want.rssi_dbm);
            compare_field("line_accepted", o_line_accepted, want.line_accepted);
            compare_field("probe_issue", o_probe_issue, want.probe_issue);
            compare_field("probe_command", o_probe_command, want.probe_command);
        end
    endtask

    // result side: check each popped word, random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_status_word();
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    task automatic push_word(input logic op, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_rx_byte <= data;
        do @(posedge i_clk); while (full);
        expected_status.push_back(predict_status(op, data));
        items_sent++;
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            atsp_pkg::REG_ENABLE: cfg_enable = value[0];
            atsp_pkg::REG_TIMEOUT: cfg_timeout = value;
            atsp_pkg::REG_POLL: cfg_poll = value;
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endfunction

    function automatic string random_prefix();
        case ($urandom_range(0, 9))
            0: return "+C";
            1: return "+CPI";
            2: return "x ";
            3: return "+CSQ:1 ";
            4: return "+CG";
            default: return "";
        endcase
    endfunction

    function automatic string number_text();
        string s;
        int    v;
        s = "";
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: s = {s, " "};
                1: s = {s, $sformatf("%c", atsp_pkg::CH_TAB)};
                2: s = {s, $sformatf("%c", atsp_pkg::CH_VT)};
                default: s = {s, $sformatf("%c", atsp_pkg::CH_FF)};
            endcase
        end
        case ($urandom_range(0, 9))
            7: s = {s, "+"};
            8: s = {s, "-"};
            default: begin
            end
        endcase
        // sometimes no digits at all
        if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 9))
                6: v = 1;
                7: v = $urandom_range(34, 300);
                8: v = $urandom_range(0, 99999);
                default: v = $urandom_range(0, 33);
            endcase
            if ($urandom_range(0, 7) == 0) s = {s, "00"};
            s = {s, $sformatf("%0d", v)};
        end
        if ($urandom_range(0, 3) == 0) s = {s, "x7"};
        return s;
    endfunction

    task automatic send_pending();
        while (line_bytes.size() != 0) begin
            if ($urandom_range(0, 99) < tick_pct) push_word(OP_TICK, 8'($urandom));
            push_word(OP_BYTE, line_bytes.pop_front());
        end
    endtask

    // mostly well-formed modem lines with random content, plus noise and tick bursts
    task automatic random_traffic(input int count);
        int   target;
        logic terminate;
        target = items_sent + count;
        while (items_sent < target) begin
            terminate = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    add_text(random_prefix());
                    add_text("+CPIN:");
                    case ($urandom_range(0, 3))
                        0, 1: add_text(" READY");
                        2: add_text(" SIM PIN");
                        default: add_text(" REA DY");
                    endcase
                end
                4, 5, 6: begin
                    add_text(random_prefix());
                    add_text("+CGATT:");
                    add_text(number_text());
                end
                7, 8, 9, 10: begin
                    add_text(random_prefix());
                    add_text("+CSQ:");
                    add_text(number_text());
                    add_text(",99");
                end
                11: begin
                    repeat ($urandom_range(1, 4))
                        line_bytes.push_back($urandom_range(0, 1) ? atsp_pkg::CH_SPACE
                                                                  : atsp_pkg::CH_TAB);
                end
                12: begin
                    // bare terminator
                end
                13: begin
                    // zero byte cuts the content short
                    if ($urandom_range(0, 1)) begin
                        add_text("+CSQ:");
                        line_bytes.push_back(atsp_pkg::CH_NUL);
                        add_text(number_text());
                    end else begin
                        add_text("+CG");
                        line_bytes.push_back(atsp_pkg::CH_NUL);
                        add_text("ATT: 1");
                    end
                end
                14: begin
                    repeat ($urandom_range(140, 170))
                        line_bytes.push_back(8'($urandom_range(32, 126)));
                    add_text("+CSQ:9");
                end
                15: begin
                    terminate = 1'b0;
                    repeat ($urandom_range(1, 8))
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                end
                16: begin
                    terminate = 1'b0;
                    repeat ($urandom_range(1, 60)) push_word(OP_TICK, 8'($urandom));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: add_text("OK");
                        1: add_text("+CME ERROR: 10");
                        default: begin
                            repeat ($urandom_range(1, 12))
                                line_bytes.push_back(8'($urandom_range(32, 126)));
                        end
                    endcase
                end
            endcase
            if (terminate) begin
                if ($urandom_range(0, 1)) line_bytes.push_back(atsp_pkg::CH_CR);
                line_bytes.push_back(atsp_pkg::CH_LF);
            end
            send_pending();
        end
    endtask

    task automatic run_phase(input int send_pct, input int pop_pct, input logic [31:0] timeout,
                             input logic [31:0] poll, input int count);
        wait_idle();
        apb_write(atsp_pkg::REG_TIMEOUT, timeout);
        apb_write(atsp_pkg::REG_POLL, poll);
        send_idle_pct = send_pct;
        pop_stall_pct <= pop_pct;
        tick_pct = 12;
        random_traffic(count);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        tick_pct = 0;
        // first tick after reset probes right away
        push_word(OP_TICK, 8'hFF);
        // empty line, then a blank one
        line_bytes.push_back(atsp_pkg::CH_LF);
        line_bytes.push_back(atsp_pkg::CH_SPACE);
        line_bytes.push_back(atsp_pkg::CH_TAB);
        line_bytes.push_back(atsp_pkg::CH_LF);
        line_bytes.push_back(atsp_pkg::CH_CR);
        // zero byte ends the content before any digit, so the value reads as 0
        line_bytes.push_back(8'hFF);
        add_text("+CSQ:");
        line_bytes.push_back(atsp_pkg::CH_NUL);
        line_bytes.push_back(8'h7F);
        line_bytes.push_back(atsp_pkg::CH_LF);
        add_text("+CSQ:31");
        line_bytes.push_back(atsp_pkg::CH_LF);
        send_pending();
        push_word(OP_TICK, 8'h00);
    endtask

    task automatic test_idle_phases();
        run_phase(0, 0, 32'd3, 32'd1, 50);
        run_phase(86, 0, $urandom_range(1, 50), $urandom_range(1, 10), 50);
        run_phase(0, 86, 32'd20, 32'd4, 50);
        run_phase(36, 36, 32'd1, 32'd2, 50);
    endtask

    task automatic test_config_extremes();
        run_phase(0, 0, 32'd0, 32'd0, 25);
        run_phase(20, 20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25);
        wait_idle();
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        run_phase(0, 0, 32'd30000, 32'd5000, 10);
    endtask

    task automatic test_disabled();
        wait_idle();
        // only bit 0 of the written value counts
        apb_write(atsp_pkg::REG_ENABLE, 32'hFFFF_FFFE);
        random_traffic(25);
        wait_idle();
        apb_write(atsp_pkg::REG_ENABLE, 32'h0000_0001);
        random_traffic(10);
    endtask

    task automatic test_backpressure();
        run_phase(0, 0, 32'd10, 32'd3, 0);
        hold_seq <= hold_seq + 1;
        random_traffic(40);
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_op = OP_BYTE;
        i_rx_byte = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_enable = atsp_pkg::RST_ENABLE[0];
        cfg_timeout = atsp_pkg::RST_TIMEOUT;
        cfg_poll = atsp_pkg::RST_POLL;
        clear_line();
        online_q = 1'b0;
        sim_ready_q = 1'b0;
        attached_q = 1'b0;
        csq_q = -1;
        heard_modem = 1'b0;
        silence_ms = '0;
        since_probe_ms = '1;
        next_probe = 2'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_idle_phases();
        test_config_extremes();
        test_disabled();
        test_backpressure();

        wait_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
